### rtl/cpc_pkg.sv
// Shared constants, types and port-match functions for the packet classifier.
package cpc_pkg;

  localparam logic [15:0] TYPE_VLAN    = 16'h8100;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;

  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_OSPF   = 8'd89;

  localparam logic [3:0]  IHL_MASK     = 4'hF;
  localparam logic [6:0]  POS_MAX      = 7'd127;

  // Byte offsets, within the frame or relative to the start of a header.
  localparam logic [6:0]  POS_TYPE_HI  = 7'd12;
  localparam logic [6:0]  POS_TYPE_LO  = 7'd13;
  localparam logic [6:0]  POS_INNER_HI = 7'd16;
  localparam logic [6:0]  POS_INNER_LO = 7'd17;
  localparam logic [4:0]  NET_OFS_BASE = 5'd14;
  localparam logic [4:0]  NET_OFS_VLAN = 5'd18;
  localparam logic [4:0]  PROTO_FIELD_OFS = 5'd9;
  localparam logic [7:0]  DPORT_HI_OFS = 8'd2;
  localparam logic [7:0]  DPORT_LO_OFS = 8'd3;

  // Minimum lengths.
  localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0]  VLAN_HDR_LEN = 8'd18;
  localparam logic [7:0]  IPV4_HDR_LEN = 8'd20;
  localparam logic [7:0]  UDP_HDR_LEN  = 8'd8;
  localparam logic [7:0]  TCP_HDR_LEN  = 8'd20;

  localparam logic [15:0] PORT_SSH     = 16'd22;
  localparam logic [15:0] PORT_DNS     = 16'd53;
  localparam logic [15:0] PORT_DHCP_S  = 16'd67;
  localparam logic [15:0] PORT_DHCP_C  = 16'd68;
  localparam logic [15:0] PORT_NTP     = 16'd123;
  localparam logic [15:0] PORT_SNMP    = 16'd161;
  localparam logic [15:0] PORT_BGP     = 16'd179;
  localparam logic [15:0] PORT_LDAP    = 16'd389;

  typedef struct packed {
    logic is_control;
    logic truncated;
  } verdict_t;

  function automatic logic udp_port_is_control(input logic [15:0] port);
    logic hit;
    hit = 1'b0;
    case (port) inside
      PORT_DNS, PORT_DHCP_S, PORT_DHCP_C, PORT_NTP, PORT_SNMP: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic tcp_port_is_control(input logic [15:0] port);
    logic hit;
    hit = 1'b0;
    case (port) inside
      PORT_SSH, PORT_DNS, PORT_BGP, PORT_LDAP: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### rtl/cpc_byte_if.sv
// Input channel: one frame byte per transfer with an end-of-frame flag.
interface cpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

### rtl/cpc_verdict_if.sv
// Result channel: one classification verdict per frame.
interface cpc_verdict_if;
  logic valid;
  logic ready;
  logic is_control;
  logic truncated;

  modport source (output valid, output is_control, output truncated, input ready);
  modport sink   (input valid, input is_control, input truncated, output ready);
endinterface

### rtl/control_plane_packet_classifier_core.sv
// Top level of the control-plane packet classifier: byte input stage, parser, verdict register.
// Frames arrive one byte per transfer on in_byte_i, starting at the destination MAC,
// with last_byte set on the final byte; exactly one verdict transfer on verdict_o
// follows each frame. The block sustains one byte per clock while in_byte_i is not stalled: the
// header tracker computes the verdict combinationally from its field registers and the byte in
// the input register, and the verdict register loads it as the last byte leaves the
// input register. in_byte_i only stalls when a last byte sits in the input
// register while the previous verdict is still waiting to be taken; non-last
// bytes never wait on verdict_o. A frame is control if it is IPv4 (optionally
// behind one 0x8100 tag) and carries ICMP, OSPF, UDP to 53/67/68/123/161 or
// TCP to 22/53/179/389; a frame that ends before the headers needed for that
// decision is reported as data with truncated set. Byte positions saturate at
// 127, beyond every header the decision looks at.
module control_plane_packet_classifier_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  cpc_byte_if.sink      in_byte_i,
  cpc_verdict_if.source verdict_o
);
  import cpc_pkg::*;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Verdict register.
  logic       out_valid_q;
  verdict_t   verdict_q;

  logic       in_xfer;
  logic       out_free;
  logic       s1_fire;
  verdict_t   hdr_verdict;

  // A non-last byte never produces a verdict, so it drains regardless of the output.
  assign out_free = !out_valid_q || verdict_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_byte_i.ready = !s1_valid_q || s1_fire;
  assign in_xfer  = in_byte_i.valid && in_byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_byte_i.packet_byte;
      s1_last_q <= in_byte_i.last_byte;
    end
  end

  cpc_hdr u_hdr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .byte_i    (s1_byte_q),
    .last_i    (s1_last_q),
    .verdict_o (hdr_verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      verdict_q <= hdr_verdict;
    end
  end

  assign verdict_o.valid      = out_valid_q;
  assign verdict_o.is_control = verdict_q.is_control;
  assign verdict_o.truncated  = verdict_q.truncated;

  // Verdict register only loads from a last byte leaving the input stage.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_last_q))
    else $error("verdict without a last byte");

  // A held byte stays in the input register until it drains.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q))
    else $error("input register lost a byte");

  // Only a last byte can be held back by the verdict register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |-> s1_last_q && out_valid_q && !verdict_o.ready)
    else $error("input stage stalled without cause");

endmodule

### rtl/cpc_hdr.sv
// Header field tracker and verdict logic, advanced by one frame byte per step.
module cpc_hdr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output cpc_pkg::verdict_t verdict_o
);
  import cpc_pkg::*;

  logic [6:0]  pos_q, pos_d;
  logic [15:0] ether_kind_q, ether_kind_d;
  logic [4:0]  net_ofs_q, net_ofs_d;
  logic [7:0]  proto_q, proto_d;
  logic [6:0]  l4_ofs_q, l4_ofs_d;
  logic [15:0] dport_q, dport_d;

  logic [15:0] ek_outer;
  logic [7:0]  len;
  logic [7:0]  pos8;
  logic [7:0]  l4_ofs8;
  verdict_t    verdict;

  // Field capture, in frame order; later fields see this byte's earlier updates.
  always_comb begin
    pos8 = {1'b0, pos_q};

    ek_outer = ether_kind_q;
    if (pos_q == POS_TYPE_HI || pos_q == POS_TYPE_LO) begin
      ek_outer = {ether_kind_q[7:0], byte_i};
    end

    net_ofs_d = net_ofs_q;
    if (pos_q == POS_TYPE_LO && ek_outer == TYPE_VLAN) begin
      net_ofs_d = NET_OFS_VLAN;
    end

    ether_kind_d = ek_outer;
    if ((pos_q == POS_INNER_HI || pos_q == POS_INNER_LO) && net_ofs_d == NET_OFS_VLAN) begin
      ether_kind_d = {ek_outer[7:0], byte_i};
    end

    l4_ofs_d = l4_ofs_q;
    if (pos_q == {2'b00, net_ofs_d}) begin
      l4_ofs_d = {2'b00, net_ofs_d} + {1'b0, byte_i[3:0] & IHL_MASK, 2'b00};
    end

    proto_d = proto_q;
    if (pos_q == {2'b00, net_ofs_d + PROTO_FIELD_OFS}) begin
      proto_d = byte_i;
    end

    l4_ofs8 = {1'b0, l4_ofs_d};
    dport_d = dport_q;
    if (pos_q > {2'b00, net_ofs_d}) begin
      if (pos8 == l4_ofs8 + DPORT_HI_OFS) begin
        dport_d[15:8] = byte_i;
      end
      if (pos8 == l4_ofs8 + DPORT_LO_OFS) begin
        dport_d[7:0] = byte_i;
      end
    end

    pos_d = (pos_q < POS_MAX) ? pos_q + 7'd1 : pos_q;
  end

  // Verdict on the frame that ends with this byte.
  always_comb begin
    len     = pos8 + 8'd1;
    verdict = '0;
    if (len < ETH_HDR_LEN) begin
      verdict.truncated = 1'b1;
    end else if (net_ofs_d == NET_OFS_VLAN && len < VLAN_HDR_LEN) begin
      verdict.truncated = 1'b1;
    end else if (ether_kind_d != TYPE_IPV4) begin
      verdict = '0;
    end else if (len < {3'b000, net_ofs_d} + IPV4_HDR_LEN) begin
      verdict.truncated = 1'b1;
    end else if (proto_d == PROTO_ICMP || proto_d == PROTO_OSPF) begin
      verdict.is_control = 1'b1;
    end else if (proto_d == PROTO_UDP) begin
      if (len < l4_ofs8 + UDP_HDR_LEN) begin
        verdict.truncated = 1'b1;
      end else begin
        verdict.is_control = udp_port_is_control(dport_d);
      end
    end else if (proto_d == PROTO_TCP) begin
      if (len < l4_ofs8 + TCP_HDR_LEN) begin
        verdict.truncated = 1'b1;
      end else begin
        verdict.is_control = tcp_port_is_control(dport_d);
      end
    end
  end

  assign verdict_o = verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ether_kind_q <= '0;
      net_ofs_q    <= NET_OFS_BASE;
      proto_q      <= '0;
      l4_ofs_q     <= '0;
      dport_q      <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q        <= '0;
        ether_kind_q <= '0;
        net_ofs_q    <= NET_OFS_BASE;
        proto_q      <= '0;
        l4_ofs_q     <= '0;
        dport_q      <= '0;
      end else begin
        pos_q        <= pos_d;
        ether_kind_q <= ether_kind_d;
        net_ofs_q    <= net_ofs_d;
        proto_q      <= proto_d;
        l4_ofs_q     <= l4_ofs_d;
        dport_q      <= dport_d;
      end
    end
  end

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && net_ofs_q == NET_OFS_BASE)
    else $error("frame state not cleared after last byte");

  a_net_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    net_ofs_q == NET_OFS_BASE || net_ofs_q == NET_OFS_VLAN)
    else $error("network offset left 14/18");

  a_verdict_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !(verdict_o.is_control && verdict_o.truncated))
    else $error("verdict both control and truncated");

endmodule
